// ----- sv/line_segment_window_clipper_macros.svh -----
// line_segment_window_clipper_macros.svh: assertion macros for the clipper
// expects clk and arst_n in the scope of each use
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define LSWC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lswc check failed");
// next-cycle implication, checked out of reset
`define LSWC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lswc check failed");
`else
`define LSWC_ASSERT_IMP(lbl, ante, cons)
`define LSWC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/lswc_pkg.sv -----
// lswc_pkg: widths, beat types and helper functions of the segment clipper
// no dependencies
package lswc_pkg;

	localparam int COORD_BITS      = 24;
	localparam int COORD_FRAC_BITS = 8;
	localparam int PARAM_FRAC_BITS = 16;

	localparam int CFG_BITS     = COORD_BITS - 1;
	localparam int CFG_IDX_BITS = 1;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int MAG_BITS     = COORD_BITS;
	localparam int QUO_BITS     = PARAM_FRAC_BITS + 1;
	localparam int T_BITS       = PARAM_FRAC_BITS + 1;
	localparam int R_BITS       = PARAM_FRAC_BITS + 3;
	localparam int PROD_BITS    = T_BITS + 1 + DIFF_BITS;
	localparam int N_TESTS      = 4;
	localparam int DIV_STEPS    = QUO_BITS;

	localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(1000 << COORD_FRAC_BITS);
	localparam logic [T_BITS-1:0]   T_ONE        = T_BITS'(1 << PARAM_FRAC_BITS);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} in_beat_t;

	typedef struct packed {
		logic                         visible;
		logic signed [COORD_BITS-1:0] clipped_start_x;
		logic signed [COORD_BITS-1:0] clipped_start_y;
		logic signed [COORD_BITS-1:0] clipped_end_x;
		logic signed [COORD_BITS-1:0] clipped_end_y;
	} out_beat_t;

	// segment geometry carried down the pipe
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x0;
		logic signed [COORD_BITS-1:0] y0;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [DIFF_BITS-1:0]  dx;
		logic signed [DIFF_BITS-1:0]  dy;
	} geom_t;

	// one edge test before division
	typedef struct packed {
		logic                pneg;
		logic                pzero;
		logic                qneg;
		logic [MAG_BITS-1:0] pmag;
		logic [MAG_BITS-1:0] qmag;
	} pre_lane_t;

	// one edge test inside the divider
	typedef struct packed {
		logic                ovf;
		logic                pneg;
		logic                pzero;
		logic                qneg;
		logic                lsb;
		logic [MAG_BITS-1:0] dmag;
		logic [MAG_BITS-1:0] rem;
		logic [QUO_BITS-1:0] quo;
	} div_lane_t;

	// one edge test with its clamped ratio
	typedef struct packed {
		logic                     pneg;
		logic                     pzero;
		logic                     qneg;
		logic signed [R_BITS-1:0] r;
	} r_lane_t;

	typedef struct packed {
		logic              ok;
		logic [T_BITS-1:0] t0;
		logic [T_BITS-1:0] t1;
	} clip_state_t;

	// one restoring division step
	function automatic div_lane_t div_step(input div_lane_t l, input logic nbit);
		logic [MAG_BITS:0] tr;
		logic [MAG_BITS:0] df;
		logic              ge;
		div_lane_t         n;
		tr = {l.rem, nbit};
		df = tr - {1'b0, l.dmag};
		ge = (tr >= {1'b0, l.dmag});
		n = l;
		n.rem = ge ? df[MAG_BITS-1:0] : tr[MAG_BITS-1:0];
		n.quo = {l.quo[QUO_BITS-2:0], ge};
		return n;
	endfunction

	// one edge test against the running entry and exit parameters
	function automatic clip_state_t edge_step(input clip_state_t s, input r_lane_t l);
		logic signed [R_BITS-1:0] t0s;
		logic signed [R_BITS-1:0] t1s;
		clip_state_t              n;
		t0s = $signed({2'b00, s.t0});
		t1s = $signed({2'b00, s.t1});
		n = s;
		if (s.ok) begin
			if (l.pzero) begin
				n.ok = !l.qneg;
			end else if (l.pneg) begin
				if (l.r > t1s) n.ok = 1'b0;
				else if (l.r > t0s) n.t0 = l.r[T_BITS-1:0];
			end else begin
				if (l.r < t0s) n.ok = 1'b0;
				else if (l.r < t1s) n.t1 = l.r[T_BITS-1:0];
			end
		end
		return n;
	endfunction

	// t times a signed difference, full width
	function automatic logic signed [PROD_BITS-1:0] mul_td(input logic [T_BITS-1:0] t,
			input logic signed [DIFF_BITS-1:0] d);
		logic signed [PROD_BITS-1:0] a;
		logic signed [PROD_BITS-1:0] b;
		a = PROD_BITS'($signed({1'b0, t}));
		b = PROD_BITS'(d);
		return a * b;
	endfunction

	// start coordinate plus floor of t*d scaled down
	function automatic logic signed [COORD_BITS-1:0] move_pt(
			input logic signed [COORD_BITS-1:0] c, input logic signed [PROD_BITS-1:0] p);
		logic signed [DIFF_BITS-1:0] sum;
		sum = DIFF_BITS'(c) + $signed(p[PARAM_FRAC_BITS +: DIFF_BITS]);
		return sum[COORD_BITS-1:0];
	endfunction

endpackage

// ----- sv/line_segment_window_clipper.sv -----
// line_segment_window_clipper: pipelined clipping of segments to the window
// uses lswc_pkg and line_segment_window_clipper_macros.svh
//
//  channel | signals                         | beat moves when
//  in      | in_valid, in_stall, in_data     | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data  | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data     | cfg_we
//
// one segment per cycle unless out_stall holds the pipe; the pipe holds setup, a 17 stage
// restoring divider (one quotient bit per stage), ratio clamp, edge tests and multiply
// the whole pipe moves as one; out_stall with a full output stalls input
// reset clears the valid bits and sets both window edges to 1000.0
`include "line_segment_window_clipper_macros.svh"
module line_segment_window_clipper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lswc_pkg::in_beat_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lswc_pkg::out_beat_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [lswc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lswc_pkg::CFG_BITS-1:0]        cfg_data
);
	import lswc_pkg::*;

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	logic                adv;

	logic                        v_s1;
	geom_t                       g_s1;
	logic signed [DIFF_BITS-1:0] p_s1 [N_TESTS];
	logic signed [DIFF_BITS-1:0] q_s1 [N_TESTS];

	logic      v_s2;
	geom_t     g_s2;
	pre_lane_t pl_s2 [N_TESTS];

	logic      dv_s [DIV_STEPS+1];
	geom_t     dg_s [DIV_STEPS+1];
	div_lane_t dl_s [DIV_STEPS+1][N_TESTS];

	logic    v_sr;
	geom_t   g_sr;
	r_lane_t rl_sr [N_TESTS];

	logic        v_e1;
	geom_t       g_e1;
	clip_state_t st_e1;
	r_lane_t     rl_e1 [2];

	logic        v_e2;
	geom_t       g_e2;
	clip_state_t st_e2;

	logic                        v_m;
	geom_t                       g_m;
	logic                        ok_m;
	logic signed [PROD_BITS-1:0] pr_m [N_TESTS];

	logic      out_valid_q;
	out_beat_t out_q;

	clip_state_t st_init;
	logic        div_rem_ok;

	// whole pipe advances unless a finished beat is held
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WINDOW_RESET;
			height_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			dv_s[0]     <= 1'b0;
			v_sr        <= 1'b0;
			v_e1        <= 1'b0;
			v_e2        <= 1'b0;
			v_m         <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			dv_s[0]     <= v_s2;
			v_sr        <= dv_s[DIV_STEPS];
			v_e1        <= v_sr;
			v_e2        <= v_e1;
			v_m         <= v_e2;
			out_valid_q <= v_m;
		end
	end

	// stage 1: differences and edge distances
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1.x0 <= in_data.start_x;
			g_s1.y0 <= in_data.start_y;
			g_s1.x1 <= in_data.end_x;
			g_s1.y1 <= in_data.end_y;
			g_s1.dx <= DIFF_BITS'(in_data.end_x) - DIFF_BITS'(in_data.start_x);
			g_s1.dy <= DIFF_BITS'(in_data.end_y) - DIFF_BITS'(in_data.start_y);
			p_s1[0] <= DIFF_BITS'(in_data.start_x) - DIFF_BITS'(in_data.end_x);
			p_s1[1] <= DIFF_BITS'(in_data.end_x) - DIFF_BITS'(in_data.start_x);
			p_s1[2] <= DIFF_BITS'(in_data.start_y) - DIFF_BITS'(in_data.end_y);
			p_s1[3] <= DIFF_BITS'(in_data.end_y) - DIFF_BITS'(in_data.start_y);
			q_s1[0] <= DIFF_BITS'(in_data.start_x);
			q_s1[1] <= $signed({2'b00, width_q}) - DIFF_BITS'(in_data.start_x);
			q_s1[2] <= DIFF_BITS'(in_data.start_y);
			q_s1[3] <= $signed({2'b00, height_q}) - DIFF_BITS'(in_data.start_y);
		end
	end

	// stage 2: signs and magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s2 <= g_s1;
			for (int i = 0; i < N_TESTS; i++) begin
				pl_s2[i].pneg  <= p_s1[i][DIFF_BITS-1];
				pl_s2[i].pzero <= (p_s1[i] == '0);
				pl_s2[i].qneg  <= q_s1[i][DIFF_BITS-1];
				pl_s2[i].pmag  <= p_s1[i][DIFF_BITS-1] ? MAG_BITS'(-p_s1[i])
				                                       : MAG_BITS'(p_s1[i]);
				pl_s2[i].qmag  <= q_s1[i][DIFF_BITS-1] ? MAG_BITS'(-q_s1[i])
				                                       : MAG_BITS'(q_s1[i]);
			end
		end
	end

	// stage 3: quotient range check and divider setup
	always_ff @(posedge clk) begin
		if (adv) begin
			dg_s[0] <= g_s2;
			for (int i = 0; i < N_TESTS; i++) begin
				dl_s[0][i].ovf   <= ({1'b0, pl_s2[i].qmag} >= {pl_s2[i].pmag, 1'b0});
				dl_s[0][i].pneg  <= pl_s2[i].pneg;
				dl_s[0][i].pzero <= pl_s2[i].pzero;
				dl_s[0][i].qneg  <= pl_s2[i].qneg;
				dl_s[0][i].lsb   <= pl_s2[i].qmag[0];
				dl_s[0][i].dmag  <= pl_s2[i].pmag;
				dl_s[0][i].rem   <= pl_s2[i].qmag >> 1;
				dl_s[0][i].quo   <= '0;
			end
		end
	end

	// divider: one quotient bit per stage, four lanes
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[k+1] <= 1'b0;
			else if (adv) dv_s[k+1] <= dv_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dg_s[k+1] <= dg_s[k];
				for (int i = 0; i < N_TESTS; i++) begin
					dl_s[k+1][i] <= div_step(dl_s[k][i], (k == 0) ? dl_s[k][i].lsb : 1'b0);
				end
			end
		end
	end

	// ratio clamped to minus one lsb .. one plus one lsb, negative ratios first
	always_ff @(posedge clk) begin
		if (adv) begin
			g_sr <= dg_s[DIV_STEPS];
			for (int i = 0; i < N_TESTS; i++) begin
				rl_sr[i].pneg  <= dl_s[DIV_STEPS][i].pneg;
				rl_sr[i].pzero <= dl_s[DIV_STEPS][i].pzero;
				rl_sr[i].qneg  <= dl_s[DIV_STEPS][i].qneg;
				if ((dl_s[DIV_STEPS][i].qneg ^ dl_s[DIV_STEPS][i].pneg)
						&& (dl_s[DIV_STEPS][i].ovf || (dl_s[DIV_STEPS][i].quo != '0))) begin
					rl_sr[i].r <= '1;
				end else if (dl_s[DIV_STEPS][i].ovf || (dl_s[DIV_STEPS][i].quo > T_ONE)) begin
					rl_sr[i].r <= $signed({2'b00, T_ONE + T_BITS'(1)});
				end else begin
					rl_sr[i].r <= $signed({2'b00, dl_s[DIV_STEPS][i].quo});
				end
			end
		end
	end

	// edge tests: left and right, then top and bottom
	always_comb begin
		st_init.ok = 1'b1;
		st_init.t0 = '0;
		st_init.t1 = T_ONE;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_e1     <= g_sr;
			st_e1    <= edge_step(edge_step(st_init, rl_sr[0]), rl_sr[1]);
			rl_e1[0] <= rl_sr[2];
			rl_e1[1] <= rl_sr[3];
			g_e2     <= g_e1;
			st_e2    <= edge_step(edge_step(st_e1, rl_e1[0]), rl_e1[1]);
		end
	end

	// parameter times difference
	always_ff @(posedge clk) begin
		if (adv) begin
			g_m     <= g_e2;
			ok_m    <= st_e2.ok;
			pr_m[0] <= mul_td(st_e2.t0, g_e2.dx);
			pr_m[1] <= mul_td(st_e2.t0, g_e2.dy);
			pr_m[2] <= mul_td(st_e2.t1, g_e2.dx);
			pr_m[3] <= mul_td(st_e2.t1, g_e2.dy);
		end
	end

	// output register: moved points or the input unchanged
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.visible <= ok_m;
			if (ok_m) begin
				out_q.clipped_start_x <= move_pt(g_m.x0, pr_m[0]);
				out_q.clipped_start_y <= move_pt(g_m.y0, pr_m[1]);
				out_q.clipped_end_x   <= move_pt(g_m.x0, pr_m[2]);
				out_q.clipped_end_y   <= move_pt(g_m.y0, pr_m[3]);
			end else begin
				out_q.clipped_start_x <= g_m.x0;
				out_q.clipped_start_y <= g_m.y0;
				out_q.clipped_end_x   <= g_m.x1;
				out_q.clipped_end_y   <= g_m.y1;
			end
		end
	end

	// divider remainder stays below the divisor in every live lane
	always_comb begin
		div_rem_ok = 1'b1;
		for (int i = 0; i < N_TESTS; i++) begin
			if (!dl_s[DIV_STEPS][i].ovf && !dl_s[DIV_STEPS][i].pzero
					&& (dl_s[DIV_STEPS][i].rem >= dl_s[DIV_STEPS][i].dmag)) begin
				div_rem_ok = 1'b0;
			end
		end
	end

	`LSWC_ASSERT_IMP(a_div_rem, dv_s[DIV_STEPS], div_rem_ok)
	`LSWC_ASSERT_IMP(a_t_order, v_e2 && st_e2.ok, st_e2.t0 <= st_e2.t1)
	`LSWC_ASSERT_IMP(a_out_rise, $rose(out_valid_q), $past(adv))
	`LSWC_ASSERT_NXT(a_held, out_valid_q && out_stall, out_valid_q)

endmodule
